// File: rtl/core/sorted_set_table_defines.svh
// Assertion macros shared by the sorted set table RTL.
`ifndef SORTED_SET_TABLE_DEFINES_SVH
`define SORTED_SET_TABLE_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define SST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted_set_table: same-cycle check failed");

// Condition implies consequence in the following cycle.
`define SST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted_set_table: next-cycle check failed");

`endif

// File: rtl/core/sst_pkg.sv
// Shared constants and types for the sorted set table.
package sst_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int IN_KEY_W      = 32;
    localparam int MODE_W        = 2;
    localparam int POS_W         = 4;
    localparam int ENT_W         = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_ERASE  = 2'd1,
        MODE_QUERY  = 2'd2
    } t_mode;

    // Update command broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic ers;
    } t_cell_cmd;

    // Per-cell compare results.
    typedef struct packed {
        logic lt;    // holds a key below the request key
        logic eq;    // holds the request key
        logic slot;  // first cell at or above the request key
    } t_cell_stat;

endpackage

// File: rtl/core/sorted_set_table.sv
// Sorted set table top level: a row of compare-and-shift cells plus result register.
//
// Usage: each input transfer (i_mode, i_key) is an insert, erase or query request.
// Every request produces exactly one result transfer (o_ok, o_table_full,
// o_position, o_entries) on the output channel.
// The result is registered and valid the cycle after the input transfer. All cells
// compare their key with the request in parallel and shift in the same edge,
// so the table sustains one request per cycle while the receiver takes results.
// The output register is the only buffer: o_ready is high while it is empty
// or being drained, so when the receiver stalls the block holds one result
// and stops taking requests until that result is transferred.
// Reset clears the entry count and the output valid; stored keys are not
// cleared since only cells below the count are ever compared.
// Keys are ordered as signed KEY_WIDTH-bit values; o_position is the sorted
// index of the key when inserted, removed or found, and o_entries the number
// of keys after the request.
`include "sorted_set_table_defines.svh"

module sorted_set_table #(
    parameter int DEPTH     = sst_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = sst_pkg::KEY_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [sst_pkg::MODE_W-1:0]    i_mode,
    input  logic signed [sst_pkg::IN_KEY_W-1:0] i_key,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_ok,
    output logic                          o_table_full,
    output logic [sst_pkg::POS_W-1:0]     o_position,
    output logic [sst_pkg::ENT_W-1:0]     o_entries
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [KEY_WIDTH-1:0]     w_key;
    logic [KEY_WIDTH-1:0]     w_cell_key [DEPTH];
    sst_pkg::t_cell_stat      w_stat [DEPTH];
    sst_pkg::t_cell_cmd       w_cmd;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [IDX_W-1:0]         w_slot_idx;
    logic                     w_present;
    logic                     w_full;
    logic                     w_in_acc;
    logic                     w_ok;
    logic                     w_tfull;
    logic                     w_use_pos;
    logic                     w_ins_do;
    logic                     w_ers_do;
    logic                     w_sorted;
    logic [IDX_W-1:0]         w_pos;
    logic [IDX_W+sst_pkg::POS_W-1:0] w_pos_ext;
    logic [CNT_W+sst_pkg::ENT_W-1:0] w_cnt_ext;
    logic                     r_out_valid;
    logic                     r_ok;
    logic                     r_full;
    logic [sst_pkg::POS_W-1:0] r_pos;
    logic [sst_pkg::ENT_W-1:0] r_ent;

    // Narrow keys keep the low bits; wide keys are zero-extended from the port.
    generate
        if (KEY_WIDTH <= sst_pkg::IN_KEY_W) begin : g_key_trunc
            assign w_key = i_key[KEY_WIDTH-1:0];
        end else begin : g_key_ext
            assign w_key = {{(KEY_WIDTH - sst_pkg::IN_KEY_W){1'b0}}, i_key};
        end
    endgenerate

    assign o_ready  = !r_out_valid || i_ready;
    assign w_in_acc = i_valid && o_ready;
    assign w_full   = (r_count == CNT_W'(DEPTH));

    assign w_cmd.ins = w_in_acc && w_ins_do;
    assign w_cmd.ers = w_in_acc && w_ers_do;

    generate
        for (genvar g = 0; g < DEPTH; g++) begin : g_cell
            logic                 w_left_lt;
            logic [KEY_WIDTH-1:0] w_left_key;
            logic [KEY_WIDTH-1:0] w_right_key;

            if (g == 0) begin : g_first
                assign w_left_lt  = 1'b1;
                assign w_left_key = w_key;
            end else begin : g_mid
                assign w_left_lt  = w_stat[g-1].lt;
                assign w_left_key = w_cell_key[g-1];
            end

            if (g == DEPTH - 1) begin : g_last
                assign w_right_key = w_cell_key[g];
            end else begin : g_inner
                assign w_right_key = w_cell_key[g+1];
            end

            sst_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_cmd       (w_cmd),
                .i_key       (w_key),
                .i_used      (r_count > CNT_W'(g)),
                .i_left_lt   (w_left_lt),
                .i_left_key  (w_left_key),
                .i_right_key (w_right_key),
                .o_key       (w_cell_key[g]),
                .o_stat      (w_stat[g])
            );
        end
    endgenerate

    // At most one cell flags the slot and at most one matches, so OR-encoding is exact.
    always_comb begin
        w_slot_idx = '0;
        w_present  = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_stat[i].slot) begin
                w_slot_idx = w_slot_idx | IDX_W'(i);
            end
            w_present = w_present | w_stat[i].eq;
        end
    end

    always_comb begin
        w_ok      = 1'b0;
        w_tfull   = 1'b0;
        w_use_pos = 1'b0;
        w_ins_do  = 1'b0;
        w_ers_do  = 1'b0;
        unique case (i_mode)
            sst_pkg::MODE_INSERT: begin
                priority if (w_present) begin
                    w_use_pos = 1'b1;
                end else if (w_full) begin
                    w_tfull = 1'b1;
                end else begin
                    w_ins_do  = 1'b1;
                    w_ok      = 1'b1;
                    w_use_pos = 1'b1;
                end
            end
            sst_pkg::MODE_ERASE: begin
                w_ers_do  = w_present;
                w_ok      = w_present;
                w_use_pos = w_present;
            end
            sst_pkg::MODE_QUERY: begin
                w_ok      = w_present;
                w_use_pos = w_present;
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        priority if (w_cmd.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_cmd.ers) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign w_pos     = w_use_pos ? w_slot_idx : '0;
    assign w_pos_ext = {{sst_pkg::POS_W{1'b0}}, w_pos};
    assign w_cnt_ext = {{sst_pkg::ENT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_in_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ok   <= w_ok;
            r_full <= w_tfull;
            r_pos  <= w_pos_ext[sst_pkg::POS_W-1:0];
            r_ent  <= w_cnt_ext[sst_pkg::ENT_W-1:0];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_ok         = r_ok;
    assign o_table_full = r_full;
    assign o_position   = r_pos;
    assign o_entries    = r_ent;

    // Occupied cells must stay in strictly ascending signed order.
    always_comb begin
        w_sorted = 1'b1;
        for (int i = 1; i < DEPTH; i++) begin
            if ((r_count > CNT_W'(i)) &&
                !($signed(w_cell_key[i-1]) < $signed(w_cell_key[i]))) begin
                w_sorted = 1'b0;
            end
        end
    end

    `SST_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH))
    `SST_ASSERT_NOW(a_table_sorted, 1'b1, w_sorted)
    `SST_ASSERT_NEXT(a_insert_grows, w_cmd.ins, r_count == $past(r_count) + CNT_W'(1))
    `SST_ASSERT_NOW(a_full_reject, r_out_valid && r_full, r_count == CNT_W'(DEPTH) && !r_ok)

endmodule

// File: rtl/core/sst_cell.sv
// One table cell: holds a key, compares it with the request and shifts with its neighbors.
module sst_cell #(
    parameter int KEY_WIDTH = sst_pkg::KEY_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  sst_pkg::t_cell_cmd     i_cmd,
    input  logic [KEY_WIDTH-1:0]   i_key,
    input  logic                   i_used,
    input  logic                   i_left_lt,
    input  logic [KEY_WIDTH-1:0]   i_left_key,
    input  logic [KEY_WIDTH-1:0]   i_right_key,
    output logic [KEY_WIDTH-1:0]   o_key,
    output sst_pkg::t_cell_stat    o_stat
);

    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] n_key;
    logic                 w_lt;
    logic                 w_eq;
    logic                 w_slot;

    assign w_lt   = i_used && ($signed(r_key) < $signed(i_key));
    assign w_eq   = i_used && (r_key == i_key);
    assign w_slot = i_left_lt && !w_lt;

    // On insert, cells at or above the slot move up; on erase they pull from the right.
    always_comb begin
        n_key = r_key;
        priority if (i_cmd.ins && !w_lt) begin
            n_key = w_slot ? i_key : i_left_key;
        end else if (i_cmd.ers && !w_lt) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key       = r_key;
    assign o_stat.lt   = w_lt;
    assign o_stat.eq   = w_eq;
    assign o_stat.slot = w_slot;

endmodule
